// ----- sv/tdes_ctr_pkg.sv -----
// Package with shared types, constants and DES tables for the Triple DES counter-mode block.
package tdes_ctr_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QueueDepth = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_ONE   = 3'd0,
    CFG_KEY_TWO   = 3'd1,
    CFG_KEY_THREE = 3'd2,
    CFG_NONCE     = 3'd3,
    CFG_MODE      = 3'd4
  } cfg_idx_t;

  // Cipher mode codes.
  typedef enum logic [1:0] {
    MODE_CTR  = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_PASS = 2'd3
  } mode_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [BlockW-1:0] cipher_in;
    logic [BlockW-1:0] data;
    mode_t             mode;
  } job_t;

  // DES permutation tables: 1-based positions counted from the MSB.
  localparam byte unsigned TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned TAB_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam byte unsigned TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam byte unsigned TAB_PC1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam byte unsigned TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam byte unsigned TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TAB_S [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Initial permutation.
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
    return r;
  endfunction

  // Final permutation.
  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
    return r;
  endfunction

  // Permuted choice one: 64-bit key to 56-bit C and D halves.
  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
    return r;
  endfunction

  // Permuted choice two: 56-bit C and D to a 48-bit round key.
  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
    return r;
  endfunction

  // One round function: expansion, key mix, S-boxes, P permutation.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
    logic [47:0] x;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  b;
    logic [5:0]  idx;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
    x = x ^ sub;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      idx = {b[5], b[0], b[4:1]};
      o[31-4*i -: 4] = TAB_S[i][idx];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-TAB_P[i]];
    return p;
  endfunction

endpackage

// ----- sv/triple_des_counter_mode_top.sv -----
// Top level of the Triple DES counter-mode block: configuration registers, front and core.
// The core works on one item at a time: its single round unit runs three DES passes of
// sixteen rounds, and the core takes no new item until the last one is handed off.
// A two-entry queue lets the front take items while the core works.
// Reset (synchronous, rst_n low) clears keys, nonce, mode, block index and all valid flags.
module triple_des_counter_mode_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tdes_ctr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tdes_ctr_pkg::BlockW-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tdes_ctr_pkg::BlockW-1:0]      in_data_block,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tdes_ctr_pkg::BlockW-1:0]      out_result_block
);

  logic [tdes_ctr_pkg::BlockW-1:0] key_one_r, key_two_r, key_three_r, nonce_r;
  tdes_ctr_pkg::mode_t mode_r;
  logic job_valid, job_take;
  tdes_ctr_pkg::job_t job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r <= '0;
      key_two_r <= '0;
      key_three_r <= '0;
      nonce_r <= '0;
      mode_r <= tdes_ctr_pkg::MODE_CTR;
    end else if (cfg_we) begin
      case (cfg_index)
        tdes_ctr_pkg::CFG_KEY_ONE:   key_one_r <= cfg_data;
        tdes_ctr_pkg::CFG_KEY_TWO:   key_two_r <= cfg_data;
        tdes_ctr_pkg::CFG_KEY_THREE: key_three_r <= cfg_data;
        tdes_ctr_pkg::CFG_NONCE:     nonce_r <= cfg_data;
        tdes_ctr_pkg::CFG_MODE:      mode_r <= tdes_ctr_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  tdes_ctr_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_block(in_data_block), .in_restart(in_restart),
    .nonce(nonce_r), .mode(mode_r),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  tdes_ctr_core u_core (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job(job), .job_take(job_take),
    .key_one(key_one_r), .key_two(key_two_r), .key_three(key_three_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_block(out_result_block)
  );

endmodule

// ----- sv/tdes_ctr_front.sv -----
// Front part: takes items, applies restart and the counter, and builds cipher jobs.
module tdes_ctr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tdes_ctr_pkg::BlockW-1:0]     in_data_block,
  input  logic                                in_restart,
  input  logic [tdes_ctr_pkg::BlockW-1:0]     nonce,
  input  tdes_ctr_pkg::mode_t                 mode,
  output logic                                job_valid,
  output tdes_ctr_pkg::job_t                  job,
  input  logic                                job_take
);

  logic [tdes_ctr_pkg::BlockW-1:0] index_r, index_nxt, index_use;
  tdes_ctr_pkg::job_t q_r [tdes_ctr_pkg::QueueDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic wr_ptr_r, rd_ptr_r;
  logic push;
  tdes_ctr_pkg::job_t new_job;

  // Queue is full when both entries hold jobs.
  assign in_stall = (cnt_r == 2'(tdes_ctr_pkg::QueueDepth));
  assign push = in_valid && !in_stall;

  // Classify the item and form the cipher input.
  always_comb begin
    index_use = in_restart ? '0 : index_r;
    index_nxt = index_r;
    new_job.data = in_data_block;
    new_job.mode = mode;
    case (mode)
      tdes_ctr_pkg::MODE_CTR: begin
        new_job.cipher_in = nonce ^ index_use;
        index_nxt = index_use + 64'd1;
      end
      default: begin
        new_job.cipher_in = in_data_block;
        index_nxt = index_use;
      end
    endcase
  end

  assign cnt_nxt = cnt_r + 2'(push) - 2'(job_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      cnt_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        index_r <= index_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (job_take) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_job;
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_ptr_r];

endmodule

// ----- sv/tdes_ctr_core.sv -----
// Back part: iterative Triple DES core, one round per cycle, plus an output register.
module tdes_ctr_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  tdes_ctr_pkg::job_t              job,
  output logic                            job_take,
  input  logic [tdes_ctr_pkg::BlockW-1:0] key_one,
  input  logic [tdes_ctr_pkg::BlockW-1:0] key_two,
  input  logic [tdes_ctr_pkg::BlockW-1:0] key_three,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tdes_ctr_pkg::BlockW-1:0] out_result_block
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] l_r, r_r;
  logic [27:0] c_r, d_r;
  logic [3:0]  round_r;
  logic [1:0]  pass_r;
  logic        dec_r;
  logic [tdes_ctr_pkg::BlockW-1:0] data_r;
  tdes_ctr_pkg::mode_t mode_r;
  logic [tdes_ctr_pkg::BlockW-1:0] res_r;
  logic        ovalid_r;
  logic [63:0] pass_key, pass_out, ip_v, final_v;
  logic [1:0]  rot;
  logic [27:0] c_step, d_step, c_use, d_use;
  logic [31:0] f_out;
  logic        pass_dec;
  logic        out_free;
  logic [1:0]  pass_n;

  assign out_free = !ovalid_r || !out_stall;

  // Key for a given pass and its direction: encrypt keys 1,2,3 E-D-E; decrypt keys 3,2,1 D-E-D.
  function automatic logic [63:0] key_sel(input logic [1:0] p, input logic dec,
                                          input logic [63:0] k1, input logic [63:0] k2,
                                          input logic [63:0] k3);
    logic [63:0] k;
    case (p)
      2'd0: k = dec ? k3 : k1;
      2'd1: k = k2;
      default: k = dec ? k1 : k3;
    endcase
    return k;
  endfunction

  // Key schedule step: encrypt rotates left before use, decrypt rotates right after use.
  always_comb begin
    pass_dec = dec_r ^ pass_r[0];
    rot = 2'(tdes_ctr_pkg::TAB_ROT[pass_dec ? 4'd15 - round_r : round_r]);
    if (!pass_dec) begin
      c_use = (rot == 2'd1) ? {c_r[26:0], c_r[27]} : {c_r[25:0], c_r[27:26]};
      d_use = (rot == 2'd1) ? {d_r[26:0], d_r[27]} : {d_r[25:0], d_r[27:26]};
      c_step = c_use;
      d_step = d_use;
    end else begin
      c_use = c_r;
      d_use = d_r;
      // Next decrypt round uses the key of round 15-(round+1); undo the rotation of key 15-round.
      c_step = (rot == 2'd1) ? {c_r[0], c_r[27:1]} : {c_r[1:0], c_r[27:2]};
      d_step = (rot == 2'd1) ? {d_r[0], d_r[27:1]} : {d_r[1:0], d_r[27:2]};
    end
    f_out = tdes_ctr_pkg::feistel(r_r, tdes_ctr_pkg::perm_pc2({c_use, d_use}));
    final_v = tdes_ctr_pkg::perm_fp({l_r ^ f_out, r_r});
    pass_n = pass_r + 2'd1;
    pass_key = key_sel(pass_n, dec_r, key_one, key_two, key_three);
    pass_out = final_v;
  end

  // The decrypt round key index uses the full left rotation of 28 at round 0.
  // C and D after sixteen encrypt rotations equal the PC1 output itself.
  assign ip_v = tdes_ctr_pkg::perm_ip(job.cipher_in);

  always_comb begin
    state_nxt = state_r;
    job_take = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          state_nxt = (job.mode == tdes_ctr_pkg::MODE_PASS) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (round_r == 4'd15 && pass_r == 2'd2) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          dec_r <= (job.mode == tdes_ctr_pkg::MODE_DEC);
          mode_r <= job.mode;
          data_r <= job.data;
          round_r <= '0;
          pass_r <= '0;
          {l_r, r_r} <= ip_v;
          {c_r, d_r} <= tdes_ctr_pkg::perm_pc1(key_sel(2'd0,
                          (job.mode == tdes_ctr_pkg::MODE_DEC), key_one, key_two, key_three));
          res_r <= job.data;
        end
      end
      ST_RUN: begin
        round_r <= round_r + 4'd1;
        if (round_r == 4'd15) begin
          pass_r <= pass_n;
          {l_r, r_r} <= tdes_ctr_pkg::perm_ip(pass_out);
          {c_r, d_r} <= tdes_ctr_pkg::perm_pc1(pass_key);
          if (pass_r == 2'd2)
            res_r <= (mode_r == tdes_ctr_pkg::MODE_CTR) ? (data_r ^ pass_out) : pass_out;
        end else begin
          l_r <= r_r;
          r_r <= l_r ^ f_out;
          c_r <= c_step;
          d_r <= d_step;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovalid_r;

  // Output holding register is loaded only when free.
  logic [tdes_ctr_pkg::BlockW-1:0] out_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) out_r <= res_r;
  end
  assign out_result_block = out_r;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the Triple DES counter-mode block with random flow control.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 60;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [tdes_ctr_pkg::CfgIdxW-1:0]  cfg_index;
  logic [tdes_ctr_pkg::BlockW-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [tdes_ctr_pkg::BlockW-1:0]   in_data_block;
  logic                              in_restart;
  logic                              out_valid;
  logic                              out_stall;
  logic [tdes_ctr_pkg::BlockW-1:0]   out_result_block;

  // Predictor state: register copies and the counter-mode block index.
  logic [63:0] key_a, key_b, key_c, ctr_nonce, ctr_index;
  tdes_ctr_pkg::mode_t cur_mode;

  logic [63:0] pending_blocks [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idle_on;
  int unsigned out_wait;

  // One directed row: optional register setup, then one item.
  typedef struct {
    bit                  set_regs;
    logic [63:0]         k1, k2, k3, nc;
    tdes_ctr_pkg::mode_t mode;
    logic [63:0]         data;
    bit                  restart;
    bit                  fixed;
    logic [63:0]         fixed_result;
  } row_t;

  triple_des_counter_mode_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_block    (in_data_block),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter with a hard limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One full DES pass over a block, encrypting or decrypting.
  function automatic logic [63:0] des_pass(input logic [63:0] key, input logic [63:0] data,
                                           input bit decrypt);
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [47:0] round_key [16];
    logic [63:0] v, w;
    logic [31:0] l, r, t, f, o;
    logic [47:0] x;
    logic [5:0]  b;
    int          k;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-tdes_ctr_pkg::TAB_PC1[i]];
    c = cd[55:28];
    d = cd[27:0];
    // Key schedule: rotate both halves, then compress to 48 bits.
    for (int i = 0; i < 16; i++) begin
      repeat (tdes_ctr_pkg::TAB_ROT[i]) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int j = 0; j < 48; j++) round_key[i][47-j] = cd[56-tdes_ctr_pkg::TAB_PC2[j]];
    end
    for (int i = 0; i < 64; i++) v[63-i] = data[64-tdes_ctr_pkg::TAB_IP[i]];
    l = v[63:32];
    r = v[31:0];
    // Sixteen rounds; decryption walks the round keys backward.
    for (int i = 0; i < 16; i++) begin
      k = decrypt ? 15 - i : i;
      for (int j = 0; j < 48; j++) x[47-j] = r[32-tdes_ctr_pkg::TAB_E[j]];
      x = x ^ round_key[k];
      for (int j = 0; j < 8; j++) begin
        b = x[47-6*j -: 6];
        o[31-4*j -: 4] = tdes_ctr_pkg::TAB_S[j][{b[5], b[0], b[4:1]}];
      end
      for (int j = 0; j < 32; j++) f[31-j] = o[32-tdes_ctr_pkg::TAB_P[j]];
      t = r;
      r = l ^ f;
      l = t;
    end
    w = {r, l};
    for (int i = 0; i < 64; i++) v[63-i] = w[64-tdes_ctr_pkg::TAB_FP[i]];
    return v;
  endfunction

  function automatic logic [63:0] tdes_forward(input logic [63:0] x);
    return des_pass(key_c, des_pass(key_b, des_pass(key_a, x, 1'b0), 1'b1), 1'b0);
  endfunction

  function automatic logic [63:0] tdes_backward(input logic [63:0] x);
    return des_pass(key_a, des_pass(key_b, des_pass(key_c, x, 1'b1), 1'b0), 1'b1);
  endfunction

  // Expected result of one accepted item; advances the block index.
  function automatic logic [63:0] predict_block(input logic [63:0] data, input bit restart);
    logic [63:0] res;
    if (restart) ctr_index = '0;
    case (cur_mode)
      tdes_ctr_pkg::MODE_CTR: begin
        res = data ^ tdes_forward(ctr_nonce ^ ctr_index);
        ctr_index = ctr_index + 64'd1;
      end
      tdes_ctr_pkg::MODE_ENC: res = tdes_forward(data);
      tdes_ctr_pkg::MODE_DEC: res = tdes_backward(data);
      default:  res = data;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 9) : 0;
  endfunction

  task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at cycle %0d: result_block %h, expected %h", cycle_count, got, want);
    mismatches++;
  endtask

  // Result side: random stall per item, compare against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch(out_result_block, 'x);
        end else if (out_result_block !== pending_blocks[0]) begin
          report_mismatch(out_result_block, pending_blocks.pop_front());
        end else begin
          void'(pending_blocks.pop_front());
        end
        out_wait = draw_wait();
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait  = out_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register; the caller lowers the write enable after a group.
  task automatic write_reg(input tdes_ctr_pkg::cfg_idx_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Wait until nothing is outstanding, then reprogram all registers.
  task automatic program_regs(input logic [63:0] k1, input logic [63:0] k2,
                              input logic [63:0] k3, input logic [63:0] nc,
                              input tdes_ctr_pkg::mode_t m);
    wait (pending_blocks.size() == 0);
    repeat (8) @(posedge clk);
    write_reg(tdes_ctr_pkg::CFG_KEY_ONE, k1);
    write_reg(tdes_ctr_pkg::CFG_KEY_TWO, k2);
    write_reg(tdes_ctr_pkg::CFG_KEY_THREE, k3);
    write_reg(tdes_ctr_pkg::CFG_NONCE, nc);
    write_reg(tdes_ctr_pkg::CFG_MODE, {62'd0, m});
    cfg_we <= 1'b0;
    key_a     = k1;
    key_b     = k2;
    key_c     = k3;
    ctr_nonce = nc;
    cur_mode  = m;
  endtask

  // Offer one item, hold it until accepted, then queue its expectation.
  task automatic send_item(input logic [63:0] data, input bit restart,
                           input bit fixed, input logic [63:0] fixed_result);
    int unsigned gap;
    logic [63:0] want;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_block <= data;
    in_restart    <= restart;
    do @(posedge clk); while (in_stall);
    want = predict_block(data, restart);
    pending_blocks = {pending_blocks, (fixed ? fixed_result : want)};
  endtask

  // Directed rows: defaults after reset, extremes, every mode and both special cases.
  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] ZeroKeyZero = 64'h8CA64DE9C1B123A7;
  row_t rows [] = '{
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h0, 0, 1, ZeroKeyZero},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, Ones, 0, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h0, 1, 1, ZeroKeyZero},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h0, 0, 0, 0},
    '{1, Ones, Ones, Ones, Ones, tdes_ctr_pkg::MODE_CTR, 64'h0, 0, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, Ones, 0, 0, 0},
    '{1, 64'h0123456789ABCDEF, 64'h23456789ABCDEF01, 64'h456789ABCDEF0123,
      64'h0, tdes_ctr_pkg::MODE_ENC, 64'h0, 0, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_ENC, Ones, 1, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_ENC, 64'h5555AAAA3333CCCC, 0, 0, 0},
    '{1, 64'h0123456789ABCDEF, 64'h23456789ABCDEF01, 64'h456789ABCDEF0123,
      64'h0, tdes_ctr_pkg::MODE_DEC, 64'h0, 0, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_DEC, Ones, 1, 0, 0},
    '{1, Ones, 64'h0, Ones, 64'h8000000000000001, tdes_ctr_pkg::MODE_CTR, 64'h1, 0, 0, 0},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h2, 0, 0, 0},
    '{1, Ones, 64'h0, Ones, 64'h8000000000000001, tdes_ctr_pkg::MODE_ENC, 64'h3, 1, 0, 0},
    '{1, Ones, 64'h0, Ones, 64'h8000000000000001, tdes_ctr_pkg::MODE_CTR, 64'h4, 0, 0, 0},
    '{1, 0, 0, 0, 0, tdes_ctr_pkg::MODE_PASS, 64'hDEADBEEF01234567, 0, 1,
      64'hDEADBEEF01234567},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_PASS, Ones, 1, 1, Ones},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_PASS, 64'h0, 0, 1, 64'h0},
    '{1, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h0, 0, 1, ZeroKeyZero},
    '{0, 0, 0, 0, 0, tdes_ctr_pkg::MODE_CTR, 64'h0, 0, 0, 0}
  };

  // Stimulus sequence.
  initial begin
    logic [63:0]         k [4];
    tdes_ctr_pkg::mode_t m;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data_block = '0;
    in_restart    = 1'b0;
    out_stall     = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    idle_on       = 1'b1;
    key_a = '0; key_b = '0; key_c = '0; ctr_nonce = '0; ctr_index = '0;
    cur_mode = tdes_ctr_pkg::MODE_CTR;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_regs) begin
        in_valid <= 1'b0;
        program_regs(rows[i].k1, rows[i].k2, rows[i].k3, rows[i].nc, rows[i].mode);
      end
      send_item(rows[i].data, rows[i].restart, rows[i].fixed, rows[i].fixed_result);
    end

    // Random phases: new settings each time, counter mode most often.
    for (int p = 0; p < 12; p++) begin
      in_valid <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(0, 5))
          0:       k[j] = '0;
          1:       k[j] = '1;
          default: k[j] = rand64();
        endcase
      end
      case ($urandom_range(0, 7))
        0, 1, 2, 3: m = tdes_ctr_pkg::MODE_CTR;
        4, 5:       m = tdes_ctr_pkg::MODE_ENC;
        6:          m = tdes_ctr_pkg::MODE_DEC;
        default:    m = tdes_ctr_pkg::MODE_PASS;
      endcase
      program_regs(k[0], k[1], k[2], k[3], m);
      idle_on = (p % 4) != 3;
      for (int n = 0; n < 115; n++) begin
        send_item(($urandom_range(0, 15) == 0) ? {64{$urandom_range(0, 1) == 1}} : rand64(),
                  $urandom_range(0, 9) == 0, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    wait (pending_blocks.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tdes_ctr_pkg.sv
sv/tdes_ctr_front.sv
sv/tdes_ctr_core.sv
sv/triple_des_counter_mode_top.sv
test/testbench.sv
